@@ rtl/core/a1rsc_pkg.sv @@
// Package for the A1 range syntax checker: parse state codes, character
// constants, the registered item type and character class helpers.
// No dependencies.
`default_nettype none

package a1rsc_pkg;

	// Parse state codes
	typedef enum logic [3:0] {
		ST_START     = 4'd0,
		ST_QUOTED    = 4'd1,
		ST_QPEND     = 4'd2,
		ST_NAME_DONE = 4'd3,
		ST_SHEET_SEP = 4'd4,
		ST_COL       = 4'd5,
		ST_ROW       = 4'd6,
		ST_RANGE_SEP = 4'd7,
		ST_ERROR     = 4'd8
	} parse_state_t;

	// Quote and separator characters
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// One item held in the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] text_byte;
		logic       end_marker;
	} item_t;

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/a1rsc_if.sv @@
// Valid/ready channel interfaces for the A1 range syntax checker:
// character input channel and verdict output channel. No dependencies.
`default_nettype none

interface a1rsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_marker;

	modport source (output valid, output text_byte, output end_marker, input ready);
	modport sink   (input valid, input text_byte, input end_marker, output ready);
endinterface

interface a1rsc_out_if;
	logic valid;
	logic ready;
	logic is_valid;

	modport source (output valid, output is_valid, input ready);
	modport sink   (input valid, input is_valid, output ready);
endinterface

`default_nettype wire

@@ rtl/core/a1_range_syntax_checker_unit.sv @@
// A1 range syntax checker, top level. A verdict passes from its end-marker
// transfer through the input register, then the result register.
// Throughput: one character or end marker per cycle, set by the parse
// state update; an end marker waits only while an unread verdict stalls.
// Reset (arst_n, asynchronous, active low) empties both registers and returns
// the parse state to start with no '!' or ':' seen.
`default_nettype none

module a1_range_syntax_checker_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	a1rsc_in_if.sink    text_in,
	a1rsc_out_if.source verdict_out
);
	import a1rsc_pkg::*;

	item_t item_s1;
	logic  item_ready;

	a1rsc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.item_s1    (item_s1),
		.item_ready (item_ready)
	);

	a1rsc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_s1     (item_s1),
		.item_ready  (item_ready),
		.verdict_out (verdict_out)
	);

	// An end marker never overwrites a verdict that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(item_s1.valid && item_s1.end_marker && verdict_out.valid && !verdict_out.ready)
		|-> !item_ready)
		else $error("end marker advanced over a stalled verdict");

	// A fresh verdict follows an end-marker transfer out of the input register
	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!verdict_out.valid || verdict_out.ready) ##1 verdict_out.valid
		|-> $past(item_s1.valid && item_s1.end_marker && item_ready))
		else $error("verdict without an end marker");

	// A held item stays in the input register
	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		(item_s1.valid && !item_ready) |=> (item_s1.valid && $stable(item_s1.end_marker)))
		else $error("stalled item lost");

	// Input stage accepts whenever a character is moving on
	a_char_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(item_s1.valid && !item_s1.end_marker) |-> text_in.ready)
		else $error("character item stalled the input");

endmodule

`default_nettype wire

@@ rtl/core/a1rsc_in_reg.sv @@
// Input register stage: captures one character or end-marker transfer.
// Depends on a1rsc_pkg and a1rsc_in_if.
`default_nettype none

module a1rsc_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	a1rsc_in_if.sink            text_in,
	output a1rsc_pkg::item_t    item_s1,
	input  wire logic           item_ready
);
	import a1rsc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Stage is free when empty or when its item moves on this cycle
	assign text_in.ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			byte_s1 <= text_in.text_byte;
			end_s1  <= text_in.end_marker;
		end
	end

	assign item_s1 = '{valid: valid_s1, text_byte: byte_s1, end_marker: end_s1};

endmodule

`default_nettype wire

@@ rtl/core/a1rsc_core.sv @@
// Parse state machine and verdict register: advances the parse state by
// one character per cycle and registers the verdict on an end marker.
// Depends on a1rsc_pkg and a1rsc_out_if.
`default_nettype none

module a1rsc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire a1rsc_pkg::item_t  item_s1,
	output logic                   item_ready,
	a1rsc_out_if.source            verdict_out
);
	import a1rsc_pkg::*;

	parse_state_t parse_state_q;
	logic         bang_q;
	logic         colon_q;
	logic         out_valid_q;
	logic         result_q;

	parse_state_t nxt_state;
	logic         nxt_bang;
	logic         nxt_colon;
	logic         verdict;
	logic         fire;
	logic [7:0]   c;

	assign c = item_s1.text_byte;

	// Characters never stall; an end marker needs room in the result register
	assign item_ready = !item_s1.end_marker || !out_valid_q || verdict_out.ready;
	assign fire       = item_s1.valid && item_ready;

	// Next-state logic for one character
	always_comb begin
		nxt_state = ST_ERROR;
		nxt_bang  = bang_q;
		nxt_colon = colon_q;
		case (parse_state_q)
			ST_START: begin
				if (c == CH_QUOTE)    nxt_state = ST_QUOTED;
				else if (is_letter(c)) nxt_state = ST_COL;
				else if (is_digit(c))  nxt_state = ST_ROW;
			end
			ST_QUOTED: begin
				nxt_state = (c == CH_QUOTE) ? ST_QPEND : ST_QUOTED;
			end
			ST_QPEND, ST_NAME_DONE: begin
				if (parse_state_q == ST_QPEND && c == CH_QUOTE) begin
					nxt_state = ST_QUOTED;
				end else if (c == CH_BANG && !bang_q) begin
					nxt_state = ST_SHEET_SEP;
					nxt_bang  = 1'b1;
				end
			end
			ST_SHEET_SEP, ST_RANGE_SEP: begin
				if (is_letter(c))     nxt_state = ST_COL;
				else if (is_digit(c)) nxt_state = ST_ROW;
			end
			ST_COL, ST_ROW: begin
				if (is_digit(c)) begin
					nxt_state = ST_ROW;
				end else if (parse_state_q == ST_COL && is_letter(c)) begin
					nxt_state = ST_COL;
				end else if (c == CH_BANG && !bang_q) begin
					nxt_state = ST_SHEET_SEP;
					nxt_bang  = 1'b1;
				end else if (c == CH_COLON && !colon_q) begin
					nxt_state = ST_RANGE_SEP;
					nxt_colon = 1'b1;
				end
			end
			default: begin
				nxt_state = ST_ERROR;
			end
		endcase
	end

	// Accepting end states
	assign verdict = parse_state_q inside {ST_COL, ST_ROW, ST_NAME_DONE, ST_QPEND};

	// Parse state; an end marker returns to the start state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_state_q <= ST_START;
			bang_q        <= 1'b0;
			colon_q       <= 1'b0;
		end else if (fire) begin
			if (item_s1.end_marker) begin
				parse_state_q <= ST_START;
				bang_q        <= 1'b0;
				colon_q       <= 1'b0;
			end else begin
				parse_state_q <= nxt_state;
				bang_q        <= nxt_bang;
				colon_q       <= nxt_colon;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && item_s1.end_marker) begin
			out_valid_q <= 1'b1;
		end else if (verdict_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item_s1.end_marker) begin
			result_q <= verdict;
		end
	end

	assign verdict_out.valid    = out_valid_q;
	assign verdict_out.is_valid = result_q;

endmodule

`default_nettype wire

@@ dv/tb_a1_range_syntax_checker_unit.sv @@
// Testbench for a1_range_syntax_checker_unit: random and directed range strings
// in, verdicts checked against an in-bench parse predictor held in a scoreboard.
// Depends on rtl/core/a1rsc_pkg.sv, rtl/core/a1rsc_if.sv and the checker RTL.
`timescale 1ns / 100ps

import a1rsc_pkg::*;

typedef logic [7:0] char_q_t[$];

// Predicts the verdict of each string and checks the verdicts that come out
class range_verdict_board;
	parse_state_t pstate;
	bit           bang_seen;
	bit           colon_seen;
	bit           verdict_q[$];
	int unsigned  mismatch_count;

	function new();
		clear();
		mismatch_count = 0;
	endfunction

	function void clear();
		pstate     = ST_START;
		bang_seen  = 1'b0;
		colon_seen = 1'b0;
	endfunction

	static function bit letter_byte(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	static function bit digit_byte(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// First character of a cell reference
	function parse_state_t cell_start(logic [7:0] c);
		if (letter_byte(c)) return ST_COL;
		if (digit_byte(c)) return ST_ROW;
		return ST_ERROR;
	endfunction

	// Only the first '!' may follow a closed sheet name
	function parse_state_t take_bang(logic [7:0] c);
		if (c == CH_BANG && !bang_seen) begin
			bang_seen = 1'b1;
			return ST_SHEET_SEP;
		end
		return ST_ERROR;
	endfunction

	// Called on every accepted input transfer
	function void note_item(logic [7:0] c, logic endm);
		parse_state_t nxt;
		if (endm) begin
			verdict_q.push_back(pstate inside {ST_COL, ST_ROW, ST_NAME_DONE, ST_QPEND});
			clear();
			return;
		end
		case (pstate)
			ST_START:                   nxt = (c == CH_QUOTE) ? ST_QUOTED : cell_start(c);
			ST_QUOTED:                  nxt = (c == CH_QUOTE) ? ST_QPEND : ST_QUOTED;
			// quote pair is a literal quote; otherwise the name is closed and only a first '!' may follow
			ST_QPEND:                   nxt = (c == CH_QUOTE) ? ST_QUOTED : take_bang(c);
			ST_NAME_DONE:               nxt = take_bang(c);
			ST_SHEET_SEP, ST_RANGE_SEP: nxt = cell_start(c);
			ST_COL, ST_ROW: begin
				if (digit_byte(c))
					nxt = ST_ROW;
				else if (pstate == ST_COL && letter_byte(c))
					nxt = ST_COL;
				else if (c == CH_BANG && !bang_seen) begin
					bang_seen = 1'b1;
					nxt = ST_SHEET_SEP;
				end else if (c == CH_COLON && !colon_seen) begin
					colon_seen = 1'b1;
					nxt = ST_RANGE_SEP;
				end else
					nxt = ST_ERROR;
			end
			default:                    nxt = ST_ERROR;
		endcase
		pstate = nxt;
	endfunction

	function int pending();
		return verdict_q.size();
	endfunction

	function void flag(string what, logic exp_v, logic got_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected is_valid=%b, got %b", $realtime, what, exp_v, got_v);
	endfunction

	// Called on every verdict transfer
	function void check_verdict(logic got);
		bit exp_v;
		if (verdict_q.size() == 0) begin
			flag("verdict with none pending", 1'bx, got);
			return;
		end
		exp_v = verdict_q.pop_front();
		if (got !== exp_v)
			flag("verdict mismatch", exp_v, got);
	endfunction
endclass

module tb_a1_range_syntax_checker_unit;

	localparam int unsigned RANDOM_ITEMS = 1250;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic clk = 1'b0;
	logic arst_n;

	a1rsc_in_if  text_in_ch();
	a1rsc_out_if verdict_ch();

	range_verdict_board board;
	int unsigned        sent_items = 0;
	int unsigned        cycle_count = 0;
	bit                 send_quiet = 1'b0;
	bit                 take_quiet = 1'b0;

	a1_range_syntax_checker_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_in     (text_in_ch),
		.verdict_out (verdict_ch)
	);

	always #2 clk = ~clk;

	// One input transfer, after a random gap unless sending is quiet
	task automatic send_item(input logic [7:0] c, input logic endm);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			text_in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_in_ch.valid      <= 1'b1;
		text_in_ch.text_byte  <= c;
		text_in_ch.end_marker <= endm;
		do @(posedge clk); while (!text_in_ch.ready);
		board.note_item(c, endm);
		sent_items++;
	endtask

	// Whole string followed by an end marker with a junk byte
	task automatic send_string(input char_q_t s);
		foreach (s[i])
			send_item(s[i], 1'b0);
		send_item(8'($urandom), 1'b1);
		if ($urandom_range(0, 15) == 0)
			send_quiet = !send_quiet;
	endtask

	function automatic char_q_t to_chars(input string w);
		char_q_t s;
		for (int i = 0; i < w.len(); i++)
			s.push_back(w[i]);
		return s;
	endfunction

	// Column letters then row digits, at least one character
	function automatic void add_cell(ref char_q_t s);
		int n_let;
		int n_dig;
		n_let = $urandom_range(0, 3);
		n_dig = $urandom_range((n_let == 0) ? 1 : 0, 3);
		repeat (n_let)
			s.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
			                                 : 8'($urandom_range(8'h61, 8'h7A)));
		repeat (n_dig)
			s.push_back(8'($urandom_range(8'h30, 8'h39)));
	endfunction

	// Mostly well-formed ranges, some corrupted, some pure noise
	function automatic char_q_t make_range();
		char_q_t    s;
		int         kind;
		logic [7:0] c;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(0, 8)) begin
				case ($urandom_range(0, 5))
					0:       s.push_back(CH_QUOTE);
					1:       s.push_back(CH_BANG);
					2:       s.push_back(CH_COLON);
					default: s.push_back(8'($urandom));
				endcase
			end
			return s;
		end
		case ($urandom_range(0, 2))
			0: ;
			1: begin
				s.push_back(CH_QUOTE);
				repeat ($urandom_range(0, 5)) begin
					c = 8'($urandom);
					if (c == CH_QUOTE || $urandom_range(0, 7) == 0)
						s.push_back(CH_QUOTE);
					s.push_back(c);
				end
				s.push_back(CH_QUOTE);
				// a closed name with no '!' is still a valid string
				if ($urandom_range(0, 3) != 0)
					s.push_back(CH_BANG);
			end
			default: begin
				add_cell(s);
				s.push_back(CH_BANG);
			end
		endcase
		if (s.size() == 0 || s[s.size() - 1] == CH_BANG) begin
			add_cell(s);
			if ($urandom_range(0, 1)) begin
				s.push_back(CH_COLON);
				add_cell(s);
			end
		end
		// corruption: stray byte or cut short
		if (kind == 1)
			s.insert($urandom_range(0, s.size()), 8'($urandom));
		else if (kind == 2)
			s = s[0:$urandom_range(0, s.size()) - 1];
		return s;
	endfunction

	// Reset and stimulus
	initial begin
		char_q_t raw;
		board = new();
		arst_n = 1'b0;
		text_in_ch.valid      = 1'b0;
		text_in_ch.text_byte  = 8'h00;
		text_in_ch.end_marker = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty string, escaped quote left inside an open quoted name,
		// sheet and range separators, zero and all-ones bytes with sticky
		// error, repeated colon, unquoted sheet with nothing after it
		send_string(raw);
		send_string(to_chars("'''"));
		send_string(to_chars("z!A:9"));
		raw = {8'h00, 8'hFF};
		send_string(raw);
		send_string(to_chars("a::"));
		send_string(to_chars("9!"));

		while (sent_items < RANDOM_ITEMS)
			send_string(make_range());
		text_in_ch.valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatch_count == 0 && board.pending() == 0)
			$display("a1_range_syntax_checker_unit verification clean");
		else
			$display("a1_range_syntax_checker_unit verification failed");
		$finish;
	end

	// Verdict receiver: random stall before each transfer unless taking is quiet
	initial begin
		int gap;
		verdict_ch.ready = 1'b0;
		forever begin
			gap = take_quiet ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				verdict_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			verdict_ch.ready <= 1'b1;
			do @(posedge clk); while (!verdict_ch.valid);
			if ($urandom_range(0, 15) == 0)
				take_quiet = !take_quiet;
		end
	end

	// Verdict monitor
	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready)
			board.check_verdict(verdict_ch.is_valid);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("a1_range_syntax_checker_unit verification failed");
			$finish;
		end
	end

endmodule
